// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Word layouts, result kinds, escape mapping and hex digit decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] CHR_QUOTE     = 8'h22;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_U         = 8'h75;

  // Largest code points that fit in one and in two UTF-8 bytes.
  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } jsu_kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_of_string;
    logic       end_of_text;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    jsu_kind_t  kind;
    logic       last_of_run;
  } jsu_out_t;

  typedef struct packed {
    logic [7:0] out_byte;
    jsu_kind_t  kind;
  } jsu_res_t;

  // All results caused by one input word; cnt is 0 to 4.
  typedef struct packed {
    logic [2:0]                cnt;
    jsu_res_t [MaxResults-1:0] res;
  } jsu_grp_t;

  // Returns {valid, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h62:   r = 8'h08;  // b
      8'h66:   r = 8'h0C;  // f
      8'h6E:   r = 8'h0A;  // n
      8'h72:   r = 8'h0D;  // r
      8'h74:   r = 8'h09;  // t
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode: string scanner state and per-word result generation
// Holds the scan phase and the \u code accumulator, and turns one input word
// into its group of up to four results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire jsu_pkg::jsu_in_t item,
  output jsu_pkg::jsu_grp_t     grp
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;

  logic [4:0]                hex;
  logic [15:0]               cp;
  jsu_res_t [MaxResults-1:0] res;
  logic [2:0]                n;

  assign hex = hex_value(item.text_byte);
  assign cp  = {acc_r[11:0], hex[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    res       = '0;
    n         = 3'd0;

    if (item.start_of_string) begin
      acc_nxt = '0;
      if (item.text_byte == CHR_QUOTE) begin
        phase_nxt = PH_BODY;
      end else begin
        phase_nxt = PH_IDLE;
        res[0]    = '{out_byte: 8'h00, kind: KIND_ERROR};
        n         = 3'd1;
      end
    end else begin
      unique case (phase_r) inside
        PH_BODY: begin
          if (item.text_byte == CHR_QUOTE) begin
            phase_nxt = PH_IDLE;
            res[0]    = '{out_byte: 8'h00, kind: KIND_DONE};
            n         = 3'd1;
          end else if (item.text_byte == CHR_BACKSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            res[0] = '{out_byte: item.text_byte, kind: KIND_DATA};
            n      = 3'd1;
          end
        end
        PH_ESC: begin
          if (item.text_byte == CHR_U) begin
            acc_nxt   = '0;
            phase_nxt = PH_HEX1;
          end else begin
            phase_nxt = PH_BODY;
            res[0]    = '{out_byte: escape_map(item.text_byte), kind: KIND_DATA};
            n         = 3'd1;
          end
        end
        PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
          if (!hex[4]) begin
            phase_nxt = PH_IDLE;
            acc_nxt   = '0;
            res[0]    = '{out_byte: 8'h00, kind: KIND_ERROR};
            n         = 3'd1;
          end else begin
            acc_nxt = cp;
            unique case (phase_r)
              PH_HEX1: phase_nxt = PH_HEX2;
              PH_HEX2: phase_nxt = PH_HEX3;
              PH_HEX3: phase_nxt = PH_HEX4;
              default: phase_nxt = PH_BODY;
            endcase
            if (phase_r == PH_HEX4) begin
              if (cp <= UTF8_MAX1) begin
                res[0] = '{out_byte: cp[7:0], kind: KIND_DATA};
                n      = 3'd1;
              end else if (cp <= UTF8_MAX2) begin
                res[0] = '{out_byte: {3'b110, cp[10:6]}, kind: KIND_DATA};
                res[1] = '{out_byte: {2'b10, cp[5:0]}, kind: KIND_DATA};
                n      = 3'd2;
              end else begin
                res[0] = '{out_byte: {4'b1110, cp[15:12]}, kind: KIND_DATA};
                res[1] = '{out_byte: {2'b10, cp[11:6]}, kind: KIND_DATA};
                res[2] = '{out_byte: {2'b10, cp[5:0]}, kind: KIND_DATA};
                n      = 3'd3;
              end
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // Text that runs out inside a string closes with an error after any data.
    if (item.end_of_text && phase_nxt != PH_IDLE) begin
      phase_nxt   = PH_IDLE;
      acc_nxt     = '0;
      res[n[1:0]] = '{out_byte: 8'h00, kind: KIND_ERROR};
      n           = n + 3'd1;
    end
  end

  assign grp.cnt = n;
  assign grp.res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/jsu_emit.sv =====
// ----------------------------------------------------------------------------
// jsu_emit: result group register and output sequencer
// Holds one group of results and presents them one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_emit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire jsu_pkg::jsu_grp_t grp,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jsu_pkg::jsu_out_t      out_data
);
  import jsu_pkg::*;

  logic                      grp_valid_r;
  logic [2:0]                cnt_r;
  logic [1:0]                idx_r;
  jsu_res_t [MaxResults-1:0] res_r;
  logic                      is_last;
  logic                      fire;

  assign is_last = ({1'b0, idx_r} == (cnt_r - 3'd1));
  assign fire    = grp_valid_r && out_ready;
  assign free    = !grp_valid_r || (out_ready && is_last);

  assign out_valid            = grp_valid_r;
  assign out_data.out_byte    = res_r[idx_r].out_byte;
  assign out_data.kind        = res_r[idx_r].kind;
  assign out_data.last_of_run = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else if (load) begin
      grp_valid_r <= 1'b1;
      cnt_r       <= grp.cnt;
      idx_r       <= '0;
    end else if (fire && is_last) begin
      grp_valid_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= grp.res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape: streaming JSON string unescaper to UTF-8
// Scans a quoted JSON string a byte at a time and emits the unescaped bytes,
// a completion marker or an error marker.
// ----------------------------------------------------------------------------
//   channel | ports                          | word
//   input   | in_valid, in_ready, in_data    | text byte, start flag, end flag
//   output  | out_valid, out_ready, out_data | byte, kind, last of run
//
// A byte passes through an input register, is decoded combinationally and its
// results go to a group register that sends one output word per cycle while
// out_ready is high. Sustained rate is one byte per cycle for bytes giving at
// most one result; more results hold the group register till the last is taken.
// Bytes with no result retire without using the group register.
// Reset (rst_n low, synchronous) empties both registers and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire jsu_pkg::jsu_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output jsu_pkg::jsu_out_t     out_data
);
  import jsu_pkg::*;

  logic     inq_valid_r;
  jsu_in_t  inq_data_r;
  jsu_grp_t grp;
  logic     grp_free;
  logic     inq_move;

  // A word with no results retires even while the group register is busy.
  assign inq_move = inq_valid_r && ((grp.cnt == 3'd0) || grp_free);
  assign in_ready = !inq_valid_r || inq_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_data_r <= in_data;
    end
  end

  jsu_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (inq_move),
    .item  (inq_data_r),
    .grp   (grp)
  );

  jsu_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (inq_move && (grp.cnt != 3'd0)),
    .grp       (grp),
    .free      (grp_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ERROR |-> out_data.last_of_run)
    else $error("error word is not the last of its run");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_DONE |-> out_data.last_of_run)
    else $error("completion word is not the last of its run");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("result run broken before its last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    inq_move && grp.cnt != 3'd0 |-> grp_free)
    else $error("group register loaded while still holding results");
`endif

endmodule

`default_nettype wire
